// File: hdl/dprw_pkg.sv
// Shared declarations for the drive packet receiver with watchdog.
// Holds field widths, configuration register indexes and the parser state type.
// No dependencies.
`default_nettype none

package dprw_pkg;

	localparam int ByteW = 8;
	localparam int SpeedW = 16;
	localparam int LimitW = 16;
	localparam int PayloadBytes = 8;
	localparam int PayIdxW = $clog2(PayloadBytes);
	localparam int NumSpeeds = PayloadBytes / 2;
	localparam int OutDataW = NumSpeeds * SpeedW;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_DRIVE_CODE = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_WATCHDOG_LIMIT = 2'd3;

	localparam logic [ByteW-1:0] HeaderFirstReset = 8'd170;
	localparam logic [ByteW-1:0] HeaderSecondReset = 8'd85;
	localparam logic [ByteW-1:0] DriveCodeReset = 8'd1;
	localparam logic [LimitW-1:0] WatchdogLimitReset = 16'd500;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_SPEED = 1'b0;
	localparam logic KIND_STOP = 1'b1;

	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_CMD = 5'b00100,
		PH_DATA = 5'b01000,
		PH_CHK = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

// File: hdl/drive_packet_receiver_watchdog_top.sv
// Drive packet receiver with watchdog: one input register stage, then a result register.
// Each item is held in the input register; a result is then loaded into the output register.
// Throughput: one item per cycle, set by the parser and running checksum;
// a result held by a stalled output holds the input register and so the input.
// Reset clears the parser, the elapsed-time counter and the handshakes, and loads the
// configuration registers with their default values; the payload store is not reset.
// Depends on dprw_pkg.
`default_nettype none

module drive_packet_receiver_watchdog_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [dprw_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [dprw_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [dprw_pkg::ByteW-1:0]    s_tdata,   // [7:0] rx_byte
	input  wire logic                          s_tuser,   // [0] command
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [dprw_pkg::OutDataW-1:0]      m_tdata,   // [15:0] speed_front_left,
	                                                      // [31:16] speed_front_right,
	                                                      // [47:32] speed_rear_left,
	                                                      // [63:48] speed_rear_right
	output logic                               m_tuser    // [0] kind
);
	import dprw_pkg::*;

	logic [ByteW-1:0] header_first_q;
	logic [ByteW-1:0] header_second_q;
	logic [ByteW-1:0] drive_code_q;
	logic [LimitW-1:0] watchdog_limit_q;

	logic s1_valid_s1;
	logic [ByteW-1:0] s1_byte_s1;
	logic s1_cmd_s1;

	phase_t phase_q;
	logic [PayIdxW-1:0] byte_cnt_q;
	logic [ByteW-1:0] chk_q;
	logic [ByteW-1:0] pay_q [PayloadBytes];
	logic [LimitW-1:0] elapsed_q;

	logic advance;
	logic [LimitW-1:0] elapsed_inc;
	logic stop_hit;
	logic frame_good;
	logic out_load;
	logic [OutDataW-1:0] speeds;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q <= HeaderFirstReset;
			header_second_q <= HeaderSecondReset;
			drive_code_q <= DriveCodeReset;
			watchdog_limit_q <= WatchdogLimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_FIRST: header_first_q <= cfg_data[ByteW-1:0];
				CFG_HEADER_SECOND: header_second_q <= cfg_data[ByteW-1:0];
				CFG_DRIVE_CODE: drive_code_q <= cfg_data[ByteW-1:0];
				CFG_WATCHDOG_LIMIT: watchdog_limit_q <= cfg_data[LimitW-1:0];
				default: ;
			endcase
		end
	end

	assign advance = s1_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_byte_s1 <= s_tdata;
			s1_cmd_s1 <= s_tuser;
		end
	end

	assign elapsed_inc = (elapsed_q == {LimitW{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
	assign stop_hit = s1_cmd_s1 == CMD_TICK && elapsed_inc >= watchdog_limit_q;
	assign frame_good = s1_cmd_s1 == CMD_BYTE && phase_q == PH_CHK && chk_q == s1_byte_s1;
	assign out_load = advance && (stop_hit || frame_good);

	always_comb begin
		for (int k = 0; k < NumSpeeds; k++) begin
			speeds[k*SpeedW +: SpeedW] = {pay_q[2*k], pay_q[2*k+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			byte_cnt_q <= '0;
			chk_q <= '0;
			elapsed_q <= '0;
		end else if (advance) begin
			if (s1_cmd_s1 == CMD_TICK) begin
				elapsed_q <= elapsed_inc;
			end else begin
				case (phase_q)
					PH_HDR0: begin
						if (s1_byte_s1 == header_first_q) phase_q <= PH_HDR1;
					end
					PH_HDR1: begin
						phase_q <= (s1_byte_s1 == header_second_q) ? PH_CMD : PH_HDR0;
					end
					PH_CMD: begin
						if (s1_byte_s1 == drive_code_q) begin
							chk_q <= s1_byte_s1;
							byte_cnt_q <= '0;
							phase_q <= PH_DATA;
						end else begin
							phase_q <= PH_HDR0;
						end
					end
					PH_DATA: begin
						chk_q <= chk_q ^ s1_byte_s1;
						byte_cnt_q <= byte_cnt_q + 1'b1;
						if (byte_cnt_q == PayIdxW'(PayloadBytes - 1)) phase_q <= PH_CHK;
					end
					PH_CHK: begin
						phase_q <= PH_HDR0;
						if (frame_good) elapsed_q <= '0;
					end
					default: phase_q <= PH_HDR0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_cmd_s1 == CMD_BYTE && phase_q == PH_DATA) begin
			pay_q[byte_cnt_q] <= s1_byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser <= stop_hit ? KIND_STOP : KIND_SPEED;
			m_tdata <= stop_hit ? '0 : speeds;
		end
	end

`ifndef NO_ASSERTIONS
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STOP |-> m_tdata == '0)
		else $error("Stop item carries non-zero speeds.");

	a_cnt_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q != '0 |-> phase_q == PH_DATA)
		else $error("Payload count is non-zero outside the payload phase.");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid_s1 && m_tvalid && !m_tready)
		else $error("Input stalled without a blocked item.");

	a_good_clears_timer: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && frame_good |=> elapsed_q == '0 && m_tvalid && m_tuser == KIND_SPEED)
		else $error("Good frame did not clear the timer or deliver speeds.");
`endif

endmodule

`default_nettype wire
